### design/pfs_pkg.sv
package pfs_pkg;

  // stack geometry
  localparam int unsigned MAX_PAGES       = 16384;
  localparam int unsigned FIRST_FREE_PAGE = 272;
  localparam int unsigned ADDR_W          = $clog2(MAX_PAGES);
  localparam int unsigned CNT_W           = $clog2(MAX_PAGES + 1);

  // field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned PAGE_W = 20;
  localparam int unsigned BYTE_W = 32;
  localparam int unsigned FC_W   = 15;
  localparam int unsigned SPAN_W = PAGE_W + 1;

  // address arithmetic
  localparam int unsigned PAGE_SHIFT    = 12;
  localparam int unsigned PAGE_LOW_MASK = 4095;
  localparam int unsigned MIN_MEM_BYTES = 524288;
  localparam int unsigned LAST_BIAS     = 256;
  localparam int unsigned ADDR_PAGES    = 1 << PAGE_W;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RANGE = 2'd2,
    OP_INIT  = 2'd3
  } pfs_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_SMALL = 2'd3
  } pfs_status_t;

  // result word handed from the sequencer to the output register
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    pfs_status_t       status;
    logic [FC_W-1:0]   count;
  } pfs_res_t;

  // stack memory access request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PAGE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } pfs_mem_req_t;

endpackage

### design/pfs_if.sv
interface pfs_in_if;
  import pfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [PAGE_W-1:0] page_in;
  logic [BYTE_W-1:0] base_addr;
  logic [BYTE_W-1:0] size_bytes;
  logic [BYTE_W-1:0] mem_bytes;

  modport source (
    output valid, opcode, page_in, base_addr, size_bytes, mem_bytes,
    input  ready
  );
  modport sink (
    input  valid, opcode, page_in, base_addr, size_bytes, mem_bytes,
    output ready
  );
endinterface

interface pfs_out_if;
  import pfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_out;
  logic [1:0]        status;
  logic [FC_W-1:0]   free_count;

  modport source (
    output valid, page_out, status, free_count,
    input  ready
  );
  modport sink (
    input  valid, page_out, status, free_count,
    output ready
  );
endinterface

### design/pfs_stack_mem.sv
module pfs_stack_mem (
  input  logic                  clk,
  input  pfs_pkg::pfs_mem_req_t req,
  output logic [pfs_pkg::PAGE_W-1:0] rdata
);
  import pfs_pkg::*;

  logic [PAGE_W-1:0] stack_mem [MAX_PAGES];
  logic [PAGE_W-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      stack_mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= stack_mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/pfs_ctrl.sv
module pfs_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  pfs_in_if.sink                     in_ch,
  output pfs_pkg::pfs_mem_req_t      mem_req,
  input  logic [pfs_pkg::PAGE_W-1:0] mem_rdata,
  output logic                       res_valid,
  input  logic                       res_ready,
  output pfs_pkg::pfs_res_t          res
);
  import pfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANGE,
    S_FILL,
    S_POP,
    S_POPW,
    S_RESULT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SPAN_W-1:0] cur_r, cur_nxt;
  logic [SPAN_W-1:0] end_r, end_nxt;
  logic              full_r, full_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  pfs_status_t       status_r, status_nxt;

  logic              stack_full;
  logic              stack_empty;
  logic [SPAN_W-1:0] range_first;
  logic [SPAN_W-1:0] range_end_raw;
  logic [SPAN_W-1:0] range_end;
  logic [SPAN_W-1:0] init_last_raw;
  logic [SPAN_W-1:0] init_last;
  pfs_op_t           op;

  assign stack_full  = (count_r == CNT_W'(MAX_PAGES));
  assign stack_empty = (count_r == '0);
  assign op          = pfs_op_t'(in_ch.opcode);

  // range bounds: first whole page up, end page down, both without wrap
  assign range_first   = SPAN_W'(({1'b0, in_ch.base_addr} + 33'(PAGE_LOW_MASK)) >> PAGE_SHIFT);
  assign range_end_raw = SPAN_W'(({1'b0, in_ch.base_addr} + {1'b0, in_ch.size_bytes})
                                 >> PAGE_SHIFT);
  assign range_end     = (range_end_raw > SPAN_W'(ADDR_PAGES)) ? SPAN_W'(ADDR_PAGES)
                                                               : range_end_raw;

  // init fill top page, clamped to the stack size
  assign init_last_raw = SPAN_W'(in_ch.mem_bytes >> PAGE_SHIFT) + SPAN_W'(LAST_BIAS);
  assign init_last     = (init_last_raw >= SPAN_W'(MAX_PAGES)) ? SPAN_W'(MAX_PAGES - 1)
                                                               : init_last_raw;

  assign in_ch.ready = (state_r == S_IDLE);

  // sequencer next state
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    end_nxt    = end_r;
    full_nxt   = full_r;
    page_nxt   = page_r;
    status_nxt = status_r;
    mem_req    = '0;
    res_valid  = 1'b0;
    res        = '{page: page_r, status: status_r, count: FC_W'(count_r)};

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          page_nxt   = '0;
          status_nxt = ST_OK;
          full_nxt   = 1'b0;
          unique case (op)
            OP_ALLOC: begin
              if (stack_empty) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESULT;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ADDR_W'(count_r - 1'b1);
                count_nxt     = count_r - 1'b1;
                state_nxt     = S_POPW;
              end
            end
            OP_FREE: begin
              if (in_ch.page_in != '0) begin
                if (stack_full) begin
                  status_nxt = ST_FULL;
                end else begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = count_r[ADDR_W-1:0];
                  mem_req.wdata = in_ch.page_in;
                  count_nxt     = count_r + 1'b1;
                end
              end
              state_nxt = S_RESULT;
            end
            OP_RANGE: begin
              cur_nxt   = range_first;
              end_nxt   = range_end;
              state_nxt = S_RANGE;
            end
            OP_INIT: begin
              if (in_ch.mem_bytes < BYTE_W'(MIN_MEM_BYTES)) begin
                status_nxt = ST_SMALL;
                state_nxt  = S_RESULT;
              end else begin
                cur_nxt   = init_last;
                state_nxt = S_FILL;
              end
            end
          endcase
        end
      end

      // ascending push, one page a cycle
      S_RANGE: begin
        if (cur_r >= end_r) begin
          state_nxt = S_RESULT;
        end else if (stack_full) begin
          status_nxt = ST_FULL;
          state_nxt  = S_RESULT;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = count_r[ADDR_W-1:0];
          mem_req.wdata = cur_r[PAGE_W-1:0];
          count_nxt     = count_r + 1'b1;
          cur_nxt       = cur_r + 1'b1;
        end
      end

      // descending push down to the first free page
      S_FILL: begin
        if (cur_r <= SPAN_W'(FIRST_FREE_PAGE)) begin
          state_nxt = S_POP;
        end else if (stack_full) begin
          full_nxt  = 1'b1;
          state_nxt = S_POP;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = count_r[ADDR_W-1:0];
          mem_req.wdata = PAGE_W'(cur_r - 1'b1);
          count_nxt     = count_r + 1'b1;
          cur_nxt       = cur_r - 1'b1;
        end
      end

      // init fill hands back the top page
      S_POP: begin
        if (stack_empty) begin
          status_nxt = full_r ? ST_FULL : ST_EMPTY;
          state_nxt  = S_RESULT;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ADDR_W'(count_r - 1'b1);
          count_nxt     = count_r - 1'b1;
          status_nxt    = full_r ? ST_FULL : ST_OK;
          state_nxt     = S_POPW;
        end
      end

      // read data arrives; pass it on or hold it
      S_POPW: begin
        res_valid = 1'b1;
        res.page  = mem_rdata;
        page_nxt  = mem_rdata;
        state_nxt = res_ready ? S_IDLE : S_RESULT;
      end

      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      full_r  <= full_nxt;
    end
    cur_r    <= cur_nxt;
    end_r    <= end_nxt;
    page_r   <= page_nxt;
    status_r <= status_nxt;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PAGES))
    else $error("stack count beyond capacity");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> !stack_full)
    else $error("push onto full stack");

  a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("read and write in the same cycle");

  a_popw_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POPW) |-> $past(mem_req.re))
    else $error("read data used without a read");

  a_pop_moves_count: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.re |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not lower the count");

endmodule

### design/page_frame_free_stack_unit.sv
// flow: alloc and free offer their result word from the sequencer in the cycle after
// acceptance; add range and init fill first push their pages, one page per cycle.
// the sequencer takes a new word only after its result has moved into the output
// register, so it never takes a new request before it is through with the last one.
// reset: synchronous active-low; clears the free count and the sequencer,
// stack memory contents are not cleared and are only read after written.
module page_frame_free_stack_unit (
  input logic     clk,
  input logic     rst_n,
  pfs_in_if.sink  in_ch,
  pfs_out_if.source out_ch
);
  import pfs_pkg::*;

  pfs_mem_req_t      mem_req;
  logic [PAGE_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  pfs_res_t          res;

  logic              out_valid_r;
  pfs_res_t          out_word_r;

  pfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  pfs_stack_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // output register: takes a word when empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_word_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.page_out   = out_word_r.page;
  assign out_ch.status     = out_word_r.status;
  assign out_ch.free_count = out_word_r.count;

  // checks
  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_word_r)))
    else $error("stalled result word changed");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result word dropped while stalled");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !res_valid)
    else $error("result offered while idle");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned LIGHT_ITEMS = 1400;
  localparam int unsigned DENSE_ITEMS = 300;

  // one request word together with the result it must produce
  typedef struct {
    pfs_op_t           op;
    logic [PAGE_W-1:0] page;
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] size;
    logic [BYTE_W-1:0] mem;
    pfs_res_t          res;
  } page_req_t;

  logic clk;
  logic rst_n;

  pfs_in_if  in_ch ();
  pfs_out_if out_ch ();

  page_frame_free_stack_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the free page stack
  logic [PAGE_W-1:0] page_pile [MAX_PAGES];
  int unsigned       pile_depth;
  bit                draining;

  page_req_t   op_backlog [$];
  pfs_res_t    result_due [$];
  int unsigned cycle_no;
  int unsigned words_seen;
  int unsigned fail_count;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_left;
  int unsigned hold_mark;
  bit          calm;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit pile_push(logic [PAGE_W-1:0] pg);
    if (pile_depth >= MAX_PAGES) return 1'b0;
    page_pile[pile_depth] = pg;
    pile_depth++;
    return 1'b1;
  endfunction

  function automatic bit pile_pop(output logic [PAGE_W-1:0] pg);
    pg = '0;
    if (pile_depth == 0) return 1'b0;
    pile_depth--;
    pg = page_pile[pile_depth];
    return 1'b1;
  endfunction

  // advance the shadow stack by one request and return its result word
  function automatic pfs_res_t apply_page_op(page_req_t rq);
    pfs_res_t          res;
    longint unsigned   first_pg;
    longint unsigned   stop_pg;
    longint unsigned   pg;
    int unsigned       top_pg;
    int unsigned       ip;
    bit                ran_out;
    logic [PAGE_W-1:0] got;
    res.page   = '0;
    res.status = ST_OK;
    ran_out    = 1'b0;
    case (rq.op)
      OP_ALLOC: begin
        if (pile_pop(got)) res.page = got;
        else res.status = ST_EMPTY;
      end
      OP_FREE: begin
        if (rq.page != '0 && !pile_push(rq.page)) res.status = ST_FULL;
      end
      OP_RANGE: begin
        // whole pages only, no wrap, end clamped to the top of the address space
        first_pg = ({32'd0, rq.base} + 64'(PAGE_LOW_MASK)) >> PAGE_SHIFT;
        stop_pg  = ({32'd0, rq.base} + {32'd0, rq.size}) >> PAGE_SHIFT;
        if (stop_pg > ADDR_PAGES) stop_pg = ADDR_PAGES;
        for (pg = first_pg; pg < stop_pg; pg++) begin
          if (!pile_push(PAGE_W'(pg))) begin
            res.status = ST_FULL;
            break;
          end
        end
      end
      default: begin
        if (rq.mem < MIN_MEM_BYTES) begin
          res.status = ST_SMALL;
        end else begin
          top_pg = (rq.mem >> PAGE_SHIFT) + LAST_BIAS;
          if (top_pg >= MAX_PAGES) top_pg = MAX_PAGES - 1;
          // descending fill, then hand back the top page
          for (ip = top_pg; ip > FIRST_FREE_PAGE; ip--) begin
            if (!pile_push(PAGE_W'(ip - 1))) begin
              ran_out = 1'b1;
              break;
            end
          end
          if (pile_pop(got)) res.page = got;
          else res.status = ST_EMPTY;
          if (ran_out) res.status = ST_FULL;
        end
      end
    endcase
    res.count = pile_depth[FC_W-1:0];
    return res;
  endfunction

  task automatic queue_op(pfs_op_t op, logic [PAGE_W-1:0] page, logic [BYTE_W-1:0] base,
                          logic [BYTE_W-1:0] size, logic [BYTE_W-1:0] mem);
    page_req_t rq;
    rq.op   = op;
    rq.page = page;
    rq.base = base;
    rq.size = size;
    rq.mem  = mem;
    rq.res  = apply_page_op(rq);
    op_backlog.push_back(rq);
  endtask

  // random request; unused fields carry random bits
  task automatic gen_random_op(bit near_full);
    int unsigned       pick;
    int unsigned       span;
    pfs_op_t           op;
    logic [PAGE_W-1:0] p;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] m;
    p = PAGE_W'($urandom);
    b = $urandom;
    s = $urandom;
    m = $urandom;
    if ($urandom_range(0, 24) == 0) p = '0;
    pick = $urandom_range(0, 99);
    if (near_full) begin
      // everything random, the full stack keeps every fill short
      op = (pick < 40) ? OP_ALLOC : (pick < 70) ? OP_FREE : (pick < 85) ? OP_RANGE : OP_INIT;
    end else begin
      // grow to a few hundred pages, then drain past empty
      if (pile_depth > 250) draining = 1'b1;
      else if (pile_depth < 3 && $urandom_range(0, 3) == 0) draining = 1'b0;
      if (draining) op = (pick < 85) ? OP_ALLOC : (pick < 95) ? OP_FREE : OP_RANGE;
      else op = (pick < 30) ? OP_ALLOC : (pick < 65) ? OP_FREE : (pick < 92) ? OP_RANGE : OP_INIT;
      if (op == OP_RANGE) begin
        span = $urandom_range(0, 99);
        if (span < 60) begin
          s = $urandom_range(0, 8 * 4096);
        end else if (span < 72) begin
          // ranges near address zero
          b = $urandom_range(0, 8191);
          s = $urandom_range(0, 6 * 4096);
        end else if (span < 84) begin
          // top of the address space with any length: one page at most
          b = 32'hFFFF_F000 | $urandom_range(0, 4095);
        end else if (span < 94) begin
          s = $urandom_range(0, 4095);
        end else begin
          s = draining ? '0 : $urandom_range(0, 256 * 4096);
        end
      end
      if (op == OP_INIT) begin
        if ($urandom_range(0, 1) == 0) m = $urandom_range(0, MIN_MEM_BYTES - 1);
        else m = MIN_MEM_BYTES + $urandom_range(0, 131071);
      end
    end
    queue_op(op, p, b, s, m);
  endtask

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int unsigned idle_len(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic settle();
    while (op_backlog.size() != 0 || result_due.size() != 0) @(posedge clk);
  endtask

  // cycle count, calm stretches and watchdog
  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no % 256 == 0) calm = ($urandom_range(0, 3) == 0);
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // input driver: presents queued words, holds each until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        result_due.push_back(op_backlog[0].res);
        op_backlog.pop_front();
        send_gap = idle_len(calm);
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (op_backlog.size() > 0) begin
          in_ch.opcode     <= op_backlog[0].op;
          in_ch.page_in    <= op_backlog[0].page;
          in_ch.base_addr  <= op_backlog[0].base;
          in_ch.size_bytes <= op_backlog[0].size;
          in_ch.mem_bytes  <= op_backlog[0].mem;
          in_ch.valid      <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready: random stalls plus long hold-offs at set word counts
  always @(posedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (!rst_n) begin
      recv_gap  = 0;
      hold_left = 0;
      hold_mark = 150;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (words_seen >= hold_mark) begin
      hold_left = HOLD_CYCLES;
      hold_mark += 700;
    end else if (recv_gap > 0) begin
      recv_gap--;
    end else begin
      rdy = 1'b1;
      recv_gap = ($urandom_range(0, 3) == 0) ? idle_len(calm) : 0;
    end
    out_ch.ready <= rdy;
  end

  // result monitor: compare each word with the oldest outstanding result
  always @(posedge clk) begin
    pfs_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (result_due.size() == 0) begin
        $error("unexpected result word: page_out %0d status %0d free_count %0d",
               out_ch.page_out, out_ch.status, out_ch.free_count);
        fail_count++;
      end else begin
        want = result_due.pop_front();
        if (out_ch.page_out !== want.page) begin
          $error("page_out mismatch: expected %0d, got %0d", want.page, out_ch.page_out);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.free_count !== want.count) begin
          $error("free_count mismatch: expected %0d, got %0d", want.count,
                 out_ch.free_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_ALLOC;
    in_ch.page_in    = '0;
    in_ch.base_addr  = '0;
    in_ch.size_bytes = '0;
    in_ch.mem_bytes  = '0;
    out_ch.ready     = 1'b0;
    pile_depth       = 0;
    draining         = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty stack, ignored page zero, memory too small
    queue_op(OP_ALLOC, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(OP_FREE, 20'h0, '0, '0, '0);
    queue_op(OP_INIT, '0, '0, '0, 32'd0);
    queue_op(OP_INIT, '0, '0, '0, MIN_MEM_BYTES - 1);
    // smallest init fill that goes through
    queue_op(OP_INIT, '0, '0, '0, MIN_MEM_BYTES);
    queue_op(OP_FREE, 20'hFFFFF, '0, '0, '0);
    queue_op(OP_ALLOC, '0, '0, '0, '0);
    // empty range, range holding page zero, unaligned edges
    queue_op(OP_RANGE, '0, 32'd0, 32'd0, '0);
    queue_op(OP_RANGE, '0, 32'd0, 32'd8192, '0);
    queue_op(OP_ALLOC, '0, '0, '0, '0);
    queue_op(OP_ALLOC, '0, '0, '0, '0);
    queue_op(OP_RANGE, '0, 32'd1, 32'd8191, '0);
    queue_op(OP_RANGE, '0, 32'd4095, 32'd1, '0);
    // no wrap past the top, end clamped to the address space
    queue_op(OP_RANGE, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    queue_op(OP_RANGE, '0, 32'hFFFF_F000, 32'h0000_2000, '0);
    queue_op(OP_ALLOC, '0, '0, '0, '0);
    settle();

    for (int unsigned i = 0; i < LIGHT_ITEMS; i++) gen_random_op(1'b0);
    settle();

    // largest init fill, then fill to the brim and push on a full stack
    queue_op(OP_INIT, '0, '0, '0, 32'hFFFF_FFFF);
    queue_op(OP_RANGE, '0, 32'd0, 32'hFFFF_FFFF, '0);
    queue_op(OP_FREE, 20'd1234, '0, '0, '0);
    queue_op(OP_FREE, 20'd0, '0, '0, '0);
    queue_op(OP_INIT, '0, '0, '0, MIN_MEM_BYTES);
    queue_op(OP_ALLOC, '0, '0, '0, '0);
    queue_op(OP_ALLOC, '0, '0, '0, '0);
    queue_op(OP_FREE, 20'h00ABC, '0, '0, '0);
    queue_op(OP_RANGE, '0, 32'd0, 32'h0000_3000, '0);
    for (int unsigned i = 0; i < DENSE_ITEMS; i++) gen_random_op(1'b1);
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### page_frame_free_stack_unit.f
design/pfs_pkg.sv
design/pfs_if.sv
design/pfs_stack_mem.sv
design/pfs_ctrl.sv
design/page_frame_free_stack_unit.sv
bench/tb_top.sv
